// ----- rtl/dqvr_pkg.sv -----
`timescale 1ns / 1ps

package dqvr_pkg;

    // action codes
    localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
    localparam logic [2:0] ACT_PUSH_BACK  = 3'd1;
    localparam logic [2:0] ACT_POP_FRONT  = 3'd2;
    localparam logic [2:0] ACT_POP_BACK   = 3'd3;
    localparam logic [2:0] ACT_REMOVE     = 3'd4;
    localparam logic [2:0] ACT_READ_OUT   = 3'd5;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // request payload
    typedef struct packed {
        logic [2:0]         action;
        logic signed [31:0] value;
    } t_req;

    // result payload
    typedef struct packed {
        logic signed [31:0] element;
        logic signed [31:0] front_value;
        logic signed [31:0] back_value;
        logic [4:0]         count;
        logic [1:0]         status;
        logic               last;
    } t_rsp;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_REMOVE,
        S_FETCH_FRONT,
        S_FETCH_BACK,
        S_FETCH_WAIT,
        S_EMIT,
        S_RO_READ,
        S_RO_EMIT
    } t_state;

endpackage

// ----- rtl/dqvr_ram.sv -----
`timescale 1ns / 1ps

module dqvr_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // single write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port, holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/dqvr_seq.sv -----
`timescale 1ns / 1ps

module dqvr_seq
    import dqvr_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_req i_req,
    output logic o_res_valid,
    output t_rsp o_res,
    input  logic i_out_free
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;

    t_state             r_state, n_state;
    logic [PW-1:0]      r_fp, n_fp;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic [2:0]         r_action, n_action;
    logic [WIDTH-1:0]   r_val, n_val;
    logic [1:0]         r_status, n_status;
    logic [CW-1:0]      r_idx, n_idx;
    logic [CW-1:0]      r_kept, n_kept;
    logic               r_pend, n_pend;
    logic [31:0]        r_front, n_front;
    logic [31:0]        r_back, n_back;

    logic               mem_we;
    logic [PW-1:0]      mem_waddr;
    logic [WIDTH-1:0]   mem_wdata;
    logic               mem_re;
    logic [PW-1:0]      mem_raddr;
    logic [WIDTH-1:0]   mem_rdata;

    logic [WIDTH-1:0]   val_in;
    logic [PW-1:0]      fp_dec;
    logic [CW-1:0]      cnt_last;
    logic               walk_done;
    logic               ro_last;

    // circular index: front pointer plus offset, wrapped once
    function automatic logic [PW-1:0] slot(input logic [PW-1:0] fp, input logic [CW-1:0] i);
        logic [SW-1:0] sum;
        sum = SW'(fp) + SW'(i);
        if (sum >= SW'(DEPTH)) begin
            sum = sum - SW'(DEPTH);
        end
        slot = PW'(sum);
    endfunction

    // sign extend a stored word to the 32-bit result field
    function automatic logic [31:0] ext_word(input logic [WIDTH-1:0] w);
        ext_word = 32'(signed'(w));
    endfunction

    dqvr_ram #(
        .DEPTH (DEPTH),
        .WIDTH (WIDTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // helpers
    assign val_in    = WIDTH'($unsigned(i_req.value));
    assign fp_dec    = (r_fp == '0) ? PW'(DEPTH - 1) : r_fp - PW'(1);
    assign cnt_last  = (r_cnt == '0) ? '0 : r_cnt - CW'(1);
    assign walk_done = (r_idx == r_cnt) && !r_pend;
    assign ro_last   = (r_idx == cnt_last);
    assign o_ready   = (r_state == S_IDLE);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = (i_req.action == ACT_REMOVE) ? S_REMOVE : S_FETCH_FRONT;
                end
            end
            S_REMOVE: begin
                if (walk_done) begin
                    n_state = S_FETCH_FRONT;
                end
            end
            S_FETCH_FRONT: n_state = S_FETCH_BACK;
            S_FETCH_BACK:  n_state = S_FETCH_WAIT;
            S_FETCH_WAIT: begin
                if (r_action == ACT_READ_OUT && r_cnt != '0) begin
                    n_state = S_RO_READ;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_RO_READ: n_state = S_RO_EMIT;
            S_RO_EMIT: begin
                if (i_out_free) begin
                    n_state = ro_last ? S_IDLE : S_RO_READ;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_fp        = r_fp;
        n_cnt       = r_cnt;
        n_action    = r_action;
        n_val       = r_val;
        n_status    = r_status;
        n_idx       = r_idx;
        n_kept      = r_kept;
        n_pend      = r_pend;
        n_front     = r_front;
        n_back      = r_back;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = val_in;
        mem_re      = 1'b0;
        mem_raddr   = '0;
        o_res_valid = 1'b0;
        o_res       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_action = i_req.action;
                    n_val    = val_in;
                    n_status = ST_OK;
                    n_idx    = '0;
                    n_kept   = '0;
                    n_pend   = 1'b0;
                    case (i_req.action)
                        ACT_PUSH_FRONT: begin
                            if (r_cnt == CW'(DEPTH)) begin
                                n_status = ST_FULL;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = fp_dec;
                                n_fp      = fp_dec;
                                n_cnt     = r_cnt + CW'(1);
                            end
                        end
                        ACT_PUSH_BACK: begin
                            if (r_cnt == CW'(DEPTH)) begin
                                n_status = ST_FULL;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = slot(r_fp, r_cnt);
                                n_cnt     = r_cnt + CW'(1);
                            end
                        end
                        ACT_POP_FRONT: begin
                            if (r_cnt == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_fp  = slot(r_fp, CW'(1));
                                n_cnt = r_cnt - CW'(1);
                            end
                        end
                        ACT_POP_BACK: begin
                            if (r_cnt == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_cnt = r_cnt - CW'(1);
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            // read entry idx while the compare unit judges the previous one
            S_REMOVE: begin
                if (r_idx != r_cnt) begin
                    mem_re    = 1'b1;
                    mem_raddr = slot(r_fp, r_idx);
                    n_idx     = r_idx + CW'(1);
                    n_pend    = 1'b1;
                end else begin
                    n_pend = 1'b0;
                end
                if (r_pend && mem_rdata != r_val) begin
                    mem_we    = 1'b1;
                    mem_waddr = slot(r_fp, r_kept);
                    mem_wdata = mem_rdata;
                    n_kept    = r_kept + CW'(1);
                end
                if (walk_done) begin
                    n_cnt = r_kept;
                    n_idx = '0;
                end
            end
            S_FETCH_FRONT: begin
                mem_re    = 1'b1;
                mem_raddr = r_fp;
            end
            S_FETCH_BACK: begin
                mem_re    = 1'b1;
                mem_raddr = slot(r_fp, cnt_last);
                n_front   = ext_word(mem_rdata);
            end
            S_FETCH_WAIT: begin
                n_back = ext_word(mem_rdata);
            end
            S_EMIT: begin
                o_res_valid       = 1'b1;
                o_res.element     = '0;
                o_res.front_value = (r_cnt != '0) ? r_front : '0;
                o_res.back_value  = (r_cnt != '0) ? r_back : '0;
                o_res.count       = 5'(r_cnt);
                o_res.status      = r_status;
                o_res.last        = 1'b1;
            end
            S_RO_READ: begin
                mem_re    = 1'b1;
                mem_raddr = slot(r_fp, r_idx);
            end
            S_RO_EMIT: begin
                o_res_valid       = 1'b1;
                o_res.element     = ext_word(mem_rdata);
                o_res.front_value = r_front;
                o_res.back_value  = r_back;
                o_res.count       = 5'(r_cnt);
                o_res.status      = ST_OK;
                o_res.last        = ro_last;
                if (i_out_free) begin
                    n_idx = r_idx + CW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fp    <= '0;
            r_cnt   <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fp    <= n_fp;
            r_cnt   <= n_cnt;
            r_pend  <= n_pend;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_action <= n_action;
        r_val    <= n_val;
        r_status <= n_status;
        r_idx    <= n_idx;
        r_kept   <= n_kept;
        r_front  <= n_front;
        r_back   <= n_back;
    end

endmodule

// ----- rtl/deque_with_value_removal_core.sv -----
`timescale 1ns / 1ps

// Bounded double-ended queue of signed words with removal by value.
// Request channel (i_valid / o_ready, i_req): action and value. Push front/back,
// pop front/back, remove every entry equal to value, or read out all entries.
// Result channel (o_valid / i_ready, o_rsp): element, front and back entries,
// count, status and a last mark on the final result of each request.
// One request is worked at a time; o_ready is high only while the sequencer idles.
// Push, pop and no-op requests: state update at acceptance, then front/back fetch
// through the registered RAM read port (fetch front, fetch back, fetch wait),
// then emit into the output register. Remove walks the stored entries one per
// cycle through the compare unit, then fetches and emits the same way. Read out
// of a non-empty queue: after the fetch, each entry goes through a RAM read state
// and then an emit state, which waits while the output register is full.
// The next request can be taken in the cycle after the final result enters the
// output register.
// The result sits in an output register; when the receiver stalls it holds there
// and the sequencer waits, so nothing is lost.
// Reset (synchronous, active low) empties the queue; the entry RAM is not cleared
// and needs no clearing pass.
module deque_with_value_removal_core
    import dqvr_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_req i_req,
    output logic o_valid,
    input  logic i_ready,
    output t_rsp o_rsp
);

    logic res_valid;
    t_rsp res;
    logic out_free;
    logic r_valid;
    t_rsp r_rsp;

    dqvr_seq #(
        .DEPTH (DEPTH),
        .WIDTH (WIDTH)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_req       (i_req),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_out_free  (out_free)
    );

    // output register takes a new result when empty or being drained
    assign out_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (out_free) begin
            r_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && res_valid) begin
            r_rsp <= res;
        end
    end

    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

endmodule

// ----- dv/deque_with_value_removal_core_tb.sv -----
`timescale 1ns / 1ps

module deque_with_value_removal_core_tb
    import dqvr_pkg::*;
();

    // unused action codes, answered with a plain status result
    localparam logic [2:0] ACT_NOP_6 = 3'd6;
    localparam logic [2:0] ACT_NOP_7 = 3'd7;

    localparam int          SLOTS = 16;
    localparam logic signed [31:0] MAXV = 32'sh7fffffff;
    localparam logic signed [31:0] MINV = 32'sh80000000;

    // directed row: request plus an optional typed-in result
    typedef struct packed {
        t_req req;
        logic typed;
        t_rsp rsp;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    t_req i_req = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    t_rsp o_rsp;

    deque_with_value_removal_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_rsp   (o_rsp)
    );

    // clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // shadow deque
    logic signed [31:0] dq_mem [SLOTS];
    logic [3:0]         dq_head = '0;
    logic [4:0]         dq_len = '0;

    t_rsp step_rsps [$];
    t_rsp expected_rsps [$];
    t_row dir_rows [$];

    int  fails = 0;
    int  n_req = 0;
    int  n_rsp = 0;
    int  n_full_drop = 0;
    int  n_empty_pop = 0;
    int  n_readout = 0;
    int  max_len = 0;
    bit  calm = 1'b0;

    // snapshot of the deque as one result
    function automatic t_rsp deque_rsp(logic signed [31:0] elem, logic [1:0] st,
                                       logic lst);
        t_rsp r;
        r.element     = elem;
        r.front_value = (dq_len != 0) ? dq_mem[dq_head] : 32'sd0;
        r.back_value  = (dq_len != 0) ? dq_mem[dq_head + 4'(dq_len - 5'd1)] : 32'sd0;
        r.count       = dq_len;
        r.status      = st;
        r.last        = lst;
        return r;
    endfunction

    // apply one request to the shadow deque, leave its results in step_rsps
    task automatic deque_step(input t_req r);
        logic [1:0]         st;
        logic [4:0]         kept;
        logic signed [31:0] e;
        st = ST_OK;
        step_rsps.delete();
        case (r.action)
            ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
                if (dq_len >= 5'(SLOTS)) begin
                    st = ST_FULL;
                    n_full_drop++;
                end else if (r.action == ACT_PUSH_FRONT) begin
                    dq_head = dq_head - 4'd1;
                    dq_mem[dq_head] = r.value;
                    dq_len++;
                end else begin
                    dq_mem[dq_head + 4'(dq_len)] = r.value;
                    dq_len++;
                end
            end
            ACT_POP_FRONT, ACT_POP_BACK: begin
                if (dq_len == 0) begin
                    st = ST_EMPTY;
                    n_empty_pop++;
                end else begin
                    if (r.action == ACT_POP_FRONT) dq_head = dq_head + 4'd1;
                    dq_len--;
                end
            end
            ACT_REMOVE: begin
                kept = '0;
                for (int i = 0; i < int'(dq_len); i++) begin
                    e = dq_mem[dq_head + 4'(i)];
                    if (e != r.value) begin
                        dq_mem[dq_head + 4'(kept)] = e;
                        kept++;
                    end
                end
                dq_len = kept;
            end
            ACT_READ_OUT: begin
                n_readout++;
                if (dq_len != 0) begin
                    for (int i = 0; i < int'(dq_len); i++)
                        step_rsps = {step_rsps,
                                     deque_rsp(dq_mem[dq_head + 4'(i)], ST_OK,
                                               (i + 1) == int'(dq_len))};
                end
            end
            default: ;
        endcase
        if (step_rsps.size() == 0) step_rsps = {step_rsps, deque_rsp(32'sd0, st, 1'b1)};
        if (int'(dq_len) > max_len) max_len = int'(dq_len);
    endtask

    // gap length: mostly short, a few long
    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 80) return $urandom_range(1, 3);
        if (p < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic void add_row(logic [2:0] act, logic signed [31:0] val,
                                    logic typed, logic signed [31:0] front,
                                    logic signed [31:0] back, logic [4:0] cnt,
                                    logic [1:0] st);
        t_row row;
        row.req.action      = act;
        row.req.value       = val;
        row.typed           = typed;
        row.rsp.element     = 32'sd0;
        row.rsp.front_value = front;
        row.rsp.back_value  = back;
        row.rsp.count       = cnt;
        row.rsp.status      = st;
        row.rsp.last        = 1'b1;
        dir_rows = {dir_rows, row};
    endfunction

    // drive one request, wait for acceptance, record its expected results
    task automatic send_req(input t_req r, input logic typed, input t_rsp typed_rsp,
                            input int gap);
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_req   <= r;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        n_req++;
        deque_step(r);
        if (typed) expected_rsps = {expected_rsps, typed_rsp};
        else foreach (step_rsps[i]) expected_rsps = {expected_rsps, step_rsps[i]};
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_valid && i_ready) begin
            n_rsp++;
            if (expected_rsps.size() == 0) begin
                $error("unexpected result: element %0d count %0d", o_rsp.element,
                       o_rsp.count);
                fails++;
            end else begin
                want = expected_rsps[0];
                expected_rsps.delete(0);
                if (o_rsp.element !== want.element) begin
                    $error("element: expected %0d, got %0d", want.element, o_rsp.element);
                    fails++;
                end
                if (o_rsp.front_value !== want.front_value) begin
                    $error("front_value: expected %0d, got %0d", want.front_value,
                           o_rsp.front_value);
                    fails++;
                end
                if (o_rsp.back_value !== want.back_value) begin
                    $error("back_value: expected %0d, got %0d", want.back_value,
                           o_rsp.back_value);
                    fails++;
                end
                if (o_rsp.count !== want.count) begin
                    $error("count: expected %0d, got %0d", want.count, o_rsp.count);
                    fails++;
                end
                if (o_rsp.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_rsp.status);
                    fails++;
                end
                if (o_rsp.last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, o_rsp.last);
                    fails++;
                end
            end
        end
    end

    // receiver: ready stretches broken by stalls, none while calm
    initial begin
        int on_len;
        int off_len;
        forever begin
            on_len = $urandom_range(1, 12);
            repeat (on_len) begin
                @(negedge i_clk);
                i_ready <= 1'b1;
            end
            if (!calm) begin
                off_len = pick_gap();
                repeat (off_len) begin
                    @(negedge i_clk);
                    i_ready <= 1'b0;
                end
            end
        end
    end

    // run limit
    initial begin
        #30ms;
        $display("TEST FAILED");
        $finish;
    end

    // stimulus
    initial begin
        logic signed [31:0] pool [6];
        t_req r;
        t_rsp none;
        int   left;
        int   mode;
        int   p;
        int   p_push;
        int   p_pop;
        int   p_rm;
        int   p_ro;
        int   gap;

        pool = '{MAXV, MINV, 32'sd0, -32'sd1, 32'sd1, 32'sh5a5a5a5a};
        none = '0;
        for (int i = 0; i < SLOTS; i++) dq_mem[i] = '0;

        // empty-queue corners, extremes, then a short mixed walk
        add_row(ACT_POP_FRONT, 32'sd0, 1'b1, 32'sd0, 32'sd0, 5'd0, ST_EMPTY);
        add_row(ACT_POP_BACK, MAXV, 1'b1, 32'sd0, 32'sd0, 5'd0, ST_EMPTY);
        add_row(ACT_READ_OUT, MINV, 1'b1, 32'sd0, 32'sd0, 5'd0, ST_OK);
        add_row(ACT_REMOVE, 32'sd0, 1'b1, 32'sd0, 32'sd0, 5'd0, ST_OK);
        add_row(ACT_NOP_6, -32'sd1, 1'b1, 32'sd0, 32'sd0, 5'd0, ST_OK);
        add_row(ACT_NOP_7, MAXV, 1'b1, 32'sd0, 32'sd0, 5'd0, ST_OK);
        add_row(ACT_PUSH_FRONT, MAXV, 1'b1, MAXV, MAXV, 5'd1, ST_OK);
        add_row(ACT_PUSH_BACK, MINV, 1'b1, MAXV, MINV, 5'd2, ST_OK);
        add_row(ACT_PUSH_FRONT, -32'sd1, 1'b0, 32'sd0, 32'sd0, 5'd0, ST_OK);
        add_row(ACT_PUSH_BACK, 32'sd0, 1'b0, 32'sd0, 32'sd0, 5'd0, ST_OK);
        add_row(ACT_PUSH_BACK, MAXV, 1'b0, 32'sd0, 32'sd0, 5'd0, ST_OK);
        add_row(ACT_PUSH_FRONT, MAXV, 1'b0, 32'sd0, 32'sd0, 5'd0, ST_OK);
        add_row(ACT_READ_OUT, 32'sd0, 1'b0, 32'sd0, 32'sd0, 5'd0, ST_OK);
        add_row(ACT_REMOVE, MAXV, 1'b0, 32'sd0, 32'sd0, 5'd0, ST_OK);
        add_row(ACT_REMOVE, 32'sd12345, 1'b0, 32'sd0, 32'sd0, 5'd0, ST_OK);
        add_row(ACT_READ_OUT, 32'sd0, 1'b0, 32'sd0, 32'sd0, 5'd0, ST_OK);
        add_row(ACT_POP_BACK, 32'sd0, 1'b0, 32'sd0, 32'sd0, 5'd0, ST_OK);
        add_row(ACT_POP_FRONT, 32'sd0, 1'b0, 32'sd0, 32'sd0, 5'd0, ST_OK);
        add_row(ACT_NOP_7, -32'sd1, 1'b0, 32'sd0, 32'sd0, 5'd0, ST_OK);
        add_row(ACT_READ_OUT, 32'sd0, 1'b0, 32'sd0, 32'sd0, 5'd0, ST_OK);
        add_row(ACT_REMOVE, MINV, 1'b0, 32'sd0, 32'sd0, 5'd0, ST_OK);
        add_row(ACT_POP_FRONT, 32'sd0, 1'b1, 32'sd0, 32'sd0, 5'd0, ST_EMPTY);

        // reset
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        foreach (dir_rows[i]) begin
            gap = ($urandom_range(0, 1) == 0) ? 0 : pick_gap();
            send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp, gap);
        end

        // random phases: fill, drain, balanced, remove-heavy
        left = 350;
        while (left > 0) begin
            mode = $urandom_range(0, 3);
            calm = ($urandom_range(0, 3) == 0);
            case (mode)
                0:       begin p_push = 70; p_pop = 80; p_rm = 88; p_ro = 96; end
                1:       begin p_push = 15; p_pop = 80; p_rm = 88; p_ro = 96; end
                2:       begin p_push = 40; p_pop = 75; p_rm = 85; p_ro = 97; end
                default: begin p_push = 45; p_pop = 55; p_rm = 85; p_ro = 96; end
            endcase
            repeat ($urandom_range(20, 50)) begin
                if (left > 0) begin
                    p = $urandom_range(0, 99);
                    if (p < p_push)
                        r.action = ($urandom_range(0, 1) == 0) ? ACT_PUSH_FRONT
                                                                : ACT_PUSH_BACK;
                    else if (p < p_pop)
                        r.action = ($urandom_range(0, 1) == 0) ? ACT_POP_FRONT
                                                                : ACT_POP_BACK;
                    else if (p < p_rm)
                        r.action = ACT_REMOVE;
                    else if (p < p_ro)
                        r.action = ACT_READ_OUT;
                    else
                        r.action = ($urandom_range(0, 1) == 0) ? ACT_NOP_6 : ACT_NOP_7;
                    // pooled values make removals hit and duplicates common
                    if ($urandom_range(0, 9) < 7) r.value = pool[$urandom_range(0, 5)];
                    else r.value = $urandom;
                    gap = (calm || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
                    send_req(r, 1'b0, none, gap);
                    left--;
                end
            end
        end
        calm = 1'b0;
        @(negedge i_clk);
        i_valid <= 1'b0;

        // drain, then watch for stray results
        while (expected_rsps.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);

        $display("sent %0d requests (%0d read-outs), checked %0d results", n_req,
                 n_readout, n_rsp);
        $display("full drops %0d, empty pops %0d, deepest fill %0d", n_full_drop,
                 n_empty_pop, max_len);
        if (fails == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end

endmodule
